// File: rtl/serial_eeprom_command_responder_defines.svh
// ----------------------------------------------------------------------------
// Serial EEPROM responder assertion macros
// Concurrent check macros on the block clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_EEPROM_COMMAND_RESPONDER_DEFINES_SVH
`define SERIAL_EEPROM_COMMAND_RESPONDER_DEFINES_SVH
`ifndef SYNTHESIS
`define SEC_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define SEC_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SEC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SEC_ASSERT_ALWAYS(name, cond, msg)
`define SEC_ASSERT_IMPLIES(name, ante, cons, msg)
`define SEC_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: rtl/sec_pkg.sv
// ----------------------------------------------------------------------------
// Serial EEPROM responder package
// Command codes, flags, device ids and the shared stage and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sec_pkg;

   localparam logic [7:0] CMD_STATUS = 8'h00;
   localparam logic [7:0] CMD_READ   = 8'h04;
   localparam logic [7:0] CMD_WRITE  = 8'h05;

   localparam logic [7:0] FLAG_NO_DEVICE = 8'h80;
   localparam logic [7:0] FLAG_SHORT     = 8'h40;
   localparam logic [7:0] ID_4K          = 8'h80;
   localparam logic [7:0] ID_16K         = 8'hC0;
   localparam logic [7:0] LEN_FULL       = 8'd3;

   localparam logic [1:0] SAVE_EEP_4K  = 2'd0;
   localparam logic [1:0] SAVE_EEP_16K = 2'd1;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_SAVE_TYPE = 1'b0;

   localparam int unsigned BLOCK_W = 64;

   typedef struct packed {
      logic [7:0] command;
      logic [7:0] rx_length;
      logic       hit;
   } stage_type;

   typedef struct packed {
      logic [7:0]         rx_length_out;
      logic [2:0]         status_mask;
      logic [7:0]         status_byte0;
      logic [7:0]         status_byte1;
      logic [7:0]         status_byte2;
      logic [BLOCK_W-1:0] read_data;
      logic               unknown_command;
   } result_type;

endpackage

// File: rtl/sec_channels.sv
// ----------------------------------------------------------------------------
// Serial EEPROM responder channels
// Valid/ready command and result channels with their payload fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface sec_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command;
   logic [7:0]  rx_length;
   logic [7:0]  block;
   logic [63:0] write_data;

   modport source (output valid, command, rx_length, block, write_data, input ready);
   modport sink (input valid, command, rx_length, block, write_data, output ready);
endinterface

interface sec_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_length_out;
   logic [2:0]  status_mask;
   logic [7:0]  status_byte0;
   logic [7:0]  status_byte1;
   logic [7:0]  status_byte2;
   logic [63:0] read_data;
   logic        unknown_command;

   modport source (output valid, rx_length_out, status_mask, status_byte0, status_byte1,
                   status_byte2, read_data, unknown_command, input ready);
   modport sink (input valid, rx_length_out, status_mask, status_byte0, status_byte1,
                 status_byte2, read_data, unknown_command, output ready);
endinterface

// File: rtl/sec_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, registered read data held without read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sec_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sec_resp.sv
// ----------------------------------------------------------------------------
// Serial EEPROM response builder
// Forms length flags, status bytes, read data and the unknown flag of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sec_resp import sec_pkg::*; (
   input  stage_type          stage,
   input  logic [BLOCK_W-1:0] store_data,
   input  logic [1:0]         save_type,
   output result_type         result
);

   logic       is_eeprom;
   logic [2:0] mask;
   logic [7:0] id;

   always_comb begin
      is_eeprom = (save_type == SAVE_EEP_4K) || (save_type == SAVE_EEP_16K);
      id        = (save_type == SAVE_EEP_4K) ? ID_4K : ID_16K;
      case (stage.rx_length[1:0])
         2'd0:    mask = 3'b000;
         2'd1:    mask = 3'b001;
         2'd2:    mask = 3'b011;
         default: mask = 3'b111;
      endcase

      result                 = '0;
      result.rx_length_out   = stage.rx_length;
      case (stage.command)
         CMD_STATUS: begin
            if (!is_eeprom) begin
               result.rx_length_out = stage.rx_length | FLAG_NO_DEVICE;
            end else begin
               if (stage.rx_length != LEN_FULL) begin
                  result.rx_length_out = stage.rx_length | FLAG_SHORT;
               end
               result.status_mask  = mask;
               result.status_byte1 = mask[1] ? id : 8'h00;
            end
         end
         CMD_READ: begin
            result.read_data = stage.hit ? store_data : '1;
         end
         CMD_WRITE: begin
            result.unknown_command = 1'b0;
         end
         default: begin
            result.unknown_command = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/serial_eeprom_command_responder.sv
// ----------------------------------------------------------------------------
// Serial EEPROM command responder
// Status, block read and block write commands against an erased-at-reset store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item (command, rx_length, block, write_data);
//   rsp returns exactly one result item per command, in order.
//   APB port: register save_type at byte address 0, written in the access
//   cycle; pready is always high.
// Path: req accept, then the block RAM read, then the result register drives rsp.
// Throughput: 1 item per cycle unless rsp is held, set by the single RAM
//   read and write port; a write lands at its accept edge, so the next
//   command already sees it.
// Reset: clears the per-block valid bits, so every block reads as all ones
//   at once with no clearing pass; save_type returns to 4 kbit EEPROM.
// Stall: when rsp is held, one more item is taken into the RAM stage, then
//   req.ready drops until the result register drains.
// Block numbers wrap modulo BLOCKS (exact for BLOCKS of 64 or more).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_eeprom_command_responder_defines.svh"
module serial_eeprom_command_responder import sec_pkg::*; #(
   parameter int unsigned BLOCKS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   sec_req_if.sink               req,
   sec_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int unsigned ADDR_W = $clog2(BLOCKS);
   localparam logic [8:0]  BLOCKS_L = 9'(BLOCKS);

   logic [1:0]        save_type_ff;
   logic [BLOCKS-1:0] valid_ff;
   stage_type         stage_ff, stage_in;
   logic              stage_valid_ff;
   result_type        result_ff, result_in;
   logic              result_valid_ff;

   logic              accept;
   logic              stage_adv;
   logic              result_free;
   logic              wr_store;
   logic [8:0]        wrap;
   logic [ADDR_W-1:0] slot;
   logic [BLOCK_W-1:0] store_data;

   always_comb begin
      wrap = {1'b0, req.block};
      for (int k = 0; k < 3; k++) begin
         if (wrap >= BLOCKS_L) begin
            wrap = wrap - BLOCKS_L;
         end
      end
      slot = wrap[ADDR_W-1:0];
   end

   assign result_free = !result_valid_ff || rsp.ready;
   assign stage_adv   = stage_valid_ff && result_free;
   assign req.ready   = !stage_valid_ff || result_free;
   assign accept      = req.valid && req.ready;
   assign wr_store    = accept && (req.command == CMD_WRITE);

   assign stage_in.command   = req.command;
   assign stage_in.rx_length = req.rx_length;
   assign stage_in.hit       = valid_ff[slot];

   sec_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (BLOCKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_store),
      .wr_addr (slot),
      .wr_data (req.write_data),
      .rd_en   (accept),
      .rd_addr (slot),
      .rd_data (store_data)
   );

   sec_resp u_resp (
      .stage      (stage_ff),
      .store_data (store_data),
      .save_type  (save_type_ff),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         save_type_ff    <= SAVE_EEP_4K;
         valid_ff        <= '0;
         stage_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && pready && (paddr[2] == REG_SAVE_TYPE)) begin
            save_type_ff <= pwdata[1:0];
         end
         if (wr_store) begin
            valid_ff[slot] <= 1'b1;
         end
         if (req.ready) begin
            stage_valid_ff <= req.valid;
         end
         if (result_free) begin
            result_valid_ff <= stage_valid_ff;
         end
      end
      if (accept) begin
         stage_ff <= stage_in;
      end
      if (stage_adv) begin
         result_ff <= result_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SAVE_TYPE) ? CSR_DATA_W'(save_type_ff) : '0;

   assign rsp.valid           = result_valid_ff;
   assign rsp.rx_length_out   = result_ff.rx_length_out;
   assign rsp.status_mask     = result_ff.status_mask;
   assign rsp.status_byte0    = result_ff.status_byte0;
   assign rsp.status_byte1    = result_ff.status_byte1;
   assign rsp.status_byte2    = result_ff.status_byte2;
   assign rsp.read_data       = result_ff.read_data;
   assign rsp.unknown_command = result_ff.unknown_command;

   `SEC_ASSERT_NEXT(a_write_marks_valid, wr_store, valid_ff[$past(slot)], "write not marked valid")
   `SEC_ASSERT_IMPLIES(a_ready_only_when_full, !req.ready, stage_valid_ff && result_valid_ff, "req stalled while room is left")
   `SEC_ASSERT_IMPLIES(a_unknown_clean, rsp.valid && rsp.unknown_command, (rsp.status_mask == 3'b000) && (rsp.read_data == '0), "unknown command carries data")
   `SEC_ASSERT_IMPLIES(a_status_id, rsp.valid && rsp.status_mask[1], (rsp.status_byte1 == ID_4K) || (rsp.status_byte1 == ID_16K), "bad device id byte")
   `SEC_ASSERT_ALWAYS(a_fixed_status_bytes, (result_ff.status_byte0 == 8'h00) || !result_valid_ff, "status byte 0 not zero")

endmodule

// File: verif/serial_eeprom_command_responder_tb.sv
// ----------------------------------------------------------------------------
// Serial EEPROM command responder testbench
// Drives status, block read, block write and unknown commands through the
// request channel under every save type, predicts each response from a
// private copy of the block store and compares every response field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module serial_eeprom_command_responder_tb import sec_pkg::*;;

   localparam int unsigned BLOCKS = 256;
   localparam logic [1:0] SAVE_NONE = 2'd2;
   localparam logic [1:0] SAVE_RESERVED = 2'd3;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned ITEMS_PER_PHASE = 316;
   localparam int unsigned LONG_HOLD = 60;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam longint unsigned CYCLE_LIMIT = 400000;

   class eeprom_scoreboard;
      logic [63:0] block_store [BLOCKS];
      logic [1:0]  save_type;
      result_type  pending_results [$];
      int unsigned mismatches;
      int unsigned n_status, n_read, n_write, n_unknown;

      function new();
         foreach (block_store[i]) block_store[i] = '1;
         save_type = SAVE_EEP_4K;
         mismatches = 0;
         n_status = 0;
         n_read = 0;
         n_write = 0;
         n_unknown = 0;
      endfunction

      function void note_command(logic [7:0] cmd, logic [7:0] len, logic [7:0] blk,
                                 logic [63:0] wdata);
         result_type want;
         logic [7:0] id;
         want = '0;
         want.rx_length_out = len;
         case (cmd)
            CMD_STATUS: begin
               n_status++;
               if (save_type != SAVE_EEP_4K && save_type != SAVE_EEP_16K) begin
                  want.rx_length_out = len | FLAG_NO_DEVICE;
               end else begin
                  id = (save_type == SAVE_EEP_4K) ? ID_4K : ID_16K;
                  if (len != LEN_FULL) begin
                     want.rx_length_out = len | FLAG_SHORT;
                     want.status_mask = 3'((4'd1 << len[1:0]) - 4'd1);
                  end else begin
                     want.status_mask = 3'b111;
                  end
                  if (want.status_mask[1]) want.status_byte1 = id;
               end
            end
            CMD_READ: begin
               n_read++;
               want.read_data = block_store[blk % BLOCKS];
            end
            CMD_WRITE: begin
               n_write++;
               block_store[blk % BLOCKS] = wdata;
            end
            default: begin
               n_unknown++;
               want.unknown_command = 1'b1;
            end
         endcase
         pending_results.push_back(want);
      endfunction

      function void compare_field(string field_name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response: expected none, actual %h", $time, got);
         end else begin
            want = pending_results.pop_front();
            compare_field("rx_length_out", want.rx_length_out, got.rx_length_out);
            compare_field("status_mask", want.status_mask, got.status_mask);
            compare_field("status_byte0", want.status_byte0, got.status_byte0);
            compare_field("status_byte1", want.status_byte1, got.status_byte1);
            compare_field("status_byte2", want.status_byte2, got.status_byte2);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("unknown_command", want.unknown_command, got.unknown_command);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   sec_req_if req_ch();
   sec_rsp_if rsp_ch();

   eeprom_scoreboard sb;
   int unsigned      req_idle_pct = 0;
   int unsigned      rsp_idle_pct = 0;
   bit               hold_request = 1'b0;
   longint unsigned  cycle_count = 0;
   logic [1:0]       phase_save_type [RANDOM_PHASES] =
      '{SAVE_EEP_16K, SAVE_NONE, SAVE_EEP_4K, SAVE_RESERVED, SAVE_EEP_16K, SAVE_EEP_4K};

   serial_eeprom_command_responder #(.BLOCKS(BLOCKS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // hold off responses at random, or for one long stretch on request
   initial begin
      int unsigned held;
      held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (held != 0) begin
            held--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            held = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result({rsp_ch.rx_length_out, rsp_ch.status_mask, rsp_ch.status_byte0,
                          rsp_ch.status_byte1, rsp_ch.status_byte2, rsp_ch.read_data,
                          rsp_ch.unknown_command});
      end
   end

   task automatic send_command(input logic [7:0] cmd, input logic [7:0] len,
                               input logic [7:0] blk, input logic [63:0] wdata);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.rx_length  <= len;
      req_ch.block      <= blk;
      req_ch.write_data <= wdata;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_command(cmd, len, blk, wdata);
   endtask

   task automatic send_random_command();
      logic [7:0]  cmd;
      logic [7:0]  len;
      logic [7:0]  blk;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) cmd = CMD_STATUS;
      else if (pick < 60) cmd = CMD_READ;
      else if (pick < 88) cmd = CMD_WRITE;
      else begin
         cmd = 8'($urandom);
         if (cmd == CMD_STATUS || cmd == CMD_READ || cmd == CMD_WRITE) cmd = ~cmd;
      end
      len = ($urandom_range(1) == 1) ? LEN_FULL : 8'($urandom);
      // favor a few blocks so reads often return earlier writes
      blk = ($urandom_range(1) == 1) ? 8'($urandom_range(7)) : 8'($urandom);
      send_command(cmd, len, blk, {$urandom, $urandom});
   endtask

   task automatic write_save_type(input logic [1:0] value);
      req_ch.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_SAVE_TYPE, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.save_type = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      sb = new();
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_ch.valid      = 1'b0;
      req_ch.command    = '0;
      req_ch.rx_length  = '0;
      req_ch.block      = '0;
      req_ch.write_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // status lengths, erased store, writes read back and unknown commands, then other save types
      send_command(CMD_STATUS, LEN_FULL, 8'h00, 64'h0);
      send_command(CMD_STATUS, 8'h00, 8'hFF, '1);
      send_command(CMD_STATUS, 8'h01, 8'h00, 64'h0);
      send_command(CMD_STATUS, 8'h02, 8'h00, 64'h0);
      send_command(CMD_STATUS, 8'hFF, 8'h00, 64'h0);
      send_command(CMD_STATUS, 8'hC3, 8'h00, 64'h0);
      send_command(CMD_READ, 8'h00, 8'h00, 64'h0);
      send_command(CMD_READ, 8'hFF, 8'hFF, '1);
      send_command(CMD_WRITE, 8'h00, 8'h00, 64'h0);
      send_command(CMD_READ, 8'h08, 8'h00, 64'h0);
      send_command(CMD_WRITE, 8'hFF, 8'hFF, 64'hA55A_C33C_0FF0_9669);
      send_command(CMD_READ, 8'h08, 8'hFF, 64'h0);
      send_command(CMD_WRITE, 8'h08, 8'h01, 64'h0123_4567_89AB_CDEF);
      send_command(CMD_READ, 8'h08, 8'h01, 64'h0);
      send_command(8'h01, 8'h03, 8'h00, 64'h0);
      send_command(8'h06, 8'h03, 8'h00, 64'h0);
      send_command(8'hFF, 8'hFF, 8'hFF, '1);
      write_save_type(SAVE_EEP_16K);
      send_command(CMD_STATUS, LEN_FULL, 8'h00, 64'h0);
      send_command(CMD_STATUS, 8'h02, 8'h00, 64'h0);
      write_save_type(SAVE_NONE);
      send_command(CMD_STATUS, LEN_FULL, 8'h00, 64'h0);
      send_command(CMD_READ, 8'h08, 8'h01, 64'h0);
      send_command(CMD_WRITE, 8'h08, 8'h02, 64'hFEDC_BA98_7654_3210);
      write_save_type(SAVE_RESERVED);
      send_command(CMD_STATUS, LEN_FULL, 8'h00, 64'h0);
      send_command(CMD_STATUS, 8'hFF, 8'h00, 64'h0);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_save_type(phase_save_type[phase]);
         case (phase / 2)
            0: begin
               req_idle_pct = 31;
               rsp_idle_pct = 82;
            end
            1: begin
               req_idle_pct = 82;
               rsp_idle_pct = 31;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         if (phase == 4) hold_request = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_command();
      end
      req_ch.valid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d commands: %0d status, %0d block read, %0d block write, %0d unknown",
               sb.n_status + sb.n_read + sb.n_write + sb.n_unknown,
               sb.n_status, sb.n_read, sb.n_write, sb.n_unknown);
      $display("all four save type codes, both-side stalls and a %0d-cycle response hold",
               LONG_HOLD);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
